>>> design/swq_pkg.sv
// Shared types and codes of the sharded work-stealing task queue.
// No dependencies; swq_if, the top level and the testbench refer to it by scoped names.
package swq_pkg;

  // Payload widths of the channels
  localparam int TASK_W     = 16;
  localparam int WIDX_W     = 3;
  localparam int STAT_W     = 3;
  localparam int TOTAL_W    = 8;
  localparam int MQS_W      = 8;
  localparam int ACTREG_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Commands
  localparam logic CMD_SUBMIT  = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_QUEUED = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_OWN    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_STOLEN = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NONE   = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_QUEUE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE    = 2'd1;

  // Reset value of the active worker register
  localparam logic [ACTREG_W-1:0] ACTIVE_RESET = 4'd8;

  // One result, less the running total
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [TASK_W-1:0] task_id;
    logic [WIDX_W-1:0] target;
    logic              wake;
  } res_t;

endpackage

>>> design/swq_if.sv
// Valid/ready channel interfaces of the task queue: command in, result out, config write.
// Depends on swq_pkg for payload widths.
interface swq_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [swq_pkg::TASK_W-1:0]    task_id;
  logic [swq_pkg::WIDX_W-1:0]    worker_index;

  modport source (output valid, output command, output task_id, output worker_index,
                  input ready);
  modport sink   (input valid, input command, input task_id, input worker_index,
                  output ready);
endinterface

interface swq_out_if;
  logic                          valid;
  logic                          ready;
  logic [swq_pkg::STAT_W-1:0]    status;
  logic [swq_pkg::TASK_W-1:0]    task_id_res;
  logic [swq_pkg::WIDX_W-1:0]    target_worker;
  logic                          wake;
  logic [swq_pkg::TOTAL_W-1:0]   queued_total;

  modport source (output valid, output status, output task_id_res, output target_worker,
                  output wake, output queued_total, input ready);
  modport sink   (input valid, input status, input task_id_res, input target_worker,
                  input wake, input queued_total, output ready);
endinterface

interface swq_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [swq_pkg::CFG_IDX_W-1:0]   index;
  logic [swq_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/swq_task_mem.sv
// Task id store: one write port, one read port with registered read data.
// No dependencies; contents are undefined until written.
module swq_task_mem #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/swq_slot_unit.sv
// Shared ring-slot adder: (base + offset - dec) mod DEPTH with one compare and subtract.
// No dependencies; base < DEPTH and offset <= DEPTH are assumed.
module swq_slot_unit #(
  parameter int DEPTH = 16,
  parameter int HW    = 4,
  parameter int CW    = 5
) (
  input  logic [HW-1:0] base,
  input  logic [CW-1:0] offset,
  input  logic          dec,
  output logic [HW-1:0] slot
);

  localparam int SUM_W = $clog2(2 * DEPTH);

  logic [SUM_W-1:0] sum;

  assign sum  = SUM_W'(base) + SUM_W'(offset) - SUM_W'(dec);
  assign slot = (sum >= SUM_W'(DEPTH)) ? HW'(sum - SUM_W'(DEPTH)) : HW'(sum);

endmodule

>>> design/sharded_work_stealing_task_queue_unit.sv
// Top level of the sharded work-stealing task queue: sequencer, queue state, result register.
// Depends on swq_pkg, swq_if, swq_task_mem and swq_slot_unit.
//
// in_ch   command transaction: submit (task_id) or request (worker_index).
// out_ch  one transaction per command: status, task_id_res, target_worker, wake and
//         queued_total (tasks queued after the command).
// cfg_ch  register writes, index 0 = max_queue_size, 1 = active_workers; always ready.
//         Write only while no command is in flight.
// A submit goes to the back of the round-robin queue; a request pops the front of its own
// queue, otherwise scans the other active queues upward (wrapping) and steals the back
// entry of the first non-empty one.
// Sequencer steps from accept to the load of the output register: EVAL, then DONE for a
// submit, an inactive requester or an empty request with one active queue; EVAL, READ
// (registered store read), DONE for an own-queue grant; EVAL, SCAN, READ, DONE for a steal,
// SCAN examining one queue per cycle through the shared slot unit; EVAL, SCAN, DONE when a
// full scan finds nothing. in_ch.ready is high only while the sequencer is idle.
// A result waits in the output register while the next command runs; if the receiver
// stalls, the following result holds in its final step and in_ch.ready stays low.
// Reset: synchronous, active low; queues empty, pointer 0, max_queue_size 0,
// active_workers 8. The task store is not cleared and needs no clearing pass.
module sharded_work_stealing_task_queue_unit #(
  parameter int MAX_WORKERS  = 8,
  parameter int SHARD_DEPTH  = 16,
  parameter int TASK_ID_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  swq_in_if.sink    in_ch,
  swq_out_if.source out_ch,
  swq_cfg_if.sink   cfg_ch
);

  localparam int WW          = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int ACT_W       = $clog2(MAX_WORKERS + 1);
  localparam int HW          = $clog2(SHARD_DEPTH);
  localparam int CW          = $clog2(SHARD_DEPTH + 1);
  localparam int STORE_DEPTH = MAX_WORKERS * SHARD_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int TOT_W       = $clog2(STORE_DEPTH + 1);
  localparam int STW         = (TASK_ID_BITS < swq_pkg::TASK_W) ? TASK_ID_BITS
                                                                 : swq_pkg::TASK_W;
  localparam int CMP_W       = (TOT_W > swq_pkg::MQS_W) ? TOT_W : swq_pkg::MQS_W;
  localparam int RQ_W        = (ACT_W > swq_pkg::WIDX_W) ? ACT_W : swq_pkg::WIDX_W;
  localparam int AC_W        = (ACT_W > swq_pkg::ACTREG_W) ? ACT_W : swq_pkg::ACTREG_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;

  // Latched command
  logic                              cmd_r;
  logic [swq_pkg::TASK_W-1:0]        task_r;
  logic [swq_pkg::WIDX_W-1:0]        req_r;

  // Steal scan
  logic [WW-1:0]    cand_r, cand_nxt;
  logic [ACT_W-1:0] steps_r, steps_nxt;

  // Queue state
  logic [HW-1:0]    head_r [MAX_WORKERS];
  logic [CW-1:0]    cnt_r  [MAX_WORKERS];
  logic [WW-1:0]    rr_r, rr_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;

  // Config registers
  logic [swq_pkg::MQS_W-1:0]    mqs_r;
  logic [swq_pkg::ACTREG_W-1:0] aw_r;

  // Result being built and output register
  swq_pkg::res_t res_r, res_nxt;
  swq_pkg::res_t out_res_r;
  logic [swq_pkg::TOTAL_W-1:0] out_total_r;
  logic out_valid_r;

  logic in_fire, cfg_fire, out_load;

  logic [ACT_W-1:0] act;
  logic [WW-1:0]    q, req_w, sel_w;
  logic             req_oor, reject, own_pop, in_scan;
  logic [HW-1:0]    head_sel, slot, mem_slot;
  logic [CW-1:0]    cnt_sel, slot_off;
  logic [ADDR_W-1:0] mem_addr;
  logic [ACT_W-1:0] q_inc, wrap_inc;
  logic [WW-1:0]    wrap_src, wrap_res;

  logic             cnt_we, head_we;
  logic [CW-1:0]    cnt_wdata;
  logic [HW-1:0]    head_wdata;
  logic             mem_we, mem_re;
  logic [STW-1:0]   mem_rdata;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  // Active queue count, clamped to 1 .. MAX_WORKERS
  always_comb begin
    if (aw_r == '0) begin
      act = ACT_W'(1);
    end else if (AC_W'(aw_r) > AC_W'(MAX_WORKERS)) begin
      act = ACT_W'(MAX_WORKERS);
    end else begin
      act = ACT_W'(aw_r);
    end
  end

  // Submit target: pointer, or queue 0 if it sits beyond the active count
  assign q       = (ACT_W'(rr_r) < act) ? rr_r : '0;
  assign req_w   = WW'(req_r);
  assign req_oor = RQ_W'(req_r) >= RQ_W'(act);

  assign in_scan = (state_r == ST_SCAN);
  assign own_pop = (state_r == ST_EVAL) && (cmd_r == swq_pkg::CMD_REQUEST);

  // One queue is looked at per cycle
  always_comb begin
    if (state_r == ST_EVAL) begin
      sel_w = (cmd_r == swq_pkg::CMD_SUBMIT) ? q : req_w;
    end else begin
      sel_w = cand_r;
    end
  end

  assign head_sel = head_r[sel_w];
  assign cnt_sel  = cnt_r[sel_w];

  assign reject = ((mqs_r != '0) && (CMP_W'(total_r) >= CMP_W'(mqs_r))) ||
                  (cnt_sel == CW'(SHARD_DEPTH));

  // Shared slot unit: back slot on submit, next head on own pop, last slot on steal
  assign slot_off = own_pop ? CW'(1) : cnt_sel;

  swq_slot_unit #(
    .DEPTH (SHARD_DEPTH),
    .HW    (HW),
    .CW    (CW)
  ) u_slot (
    .base   (head_sel),
    .offset (slot_off),
    .dec    (in_scan),
    .slot   (slot)
  );

  assign mem_slot = own_pop ? head_sel : slot;
  assign mem_addr = ADDR_W'(sel_w) * ADDR_W'(SHARD_DEPTH) + ADDR_W'(mem_slot);

  // Wrapping increments for the round-robin pointer and the scan candidate
  assign q_inc    = ACT_W'(q) + ACT_W'(1);
  assign wrap_src = (state_r == ST_EVAL) ? req_w : cand_r;
  assign wrap_inc = ACT_W'(wrap_src) + ACT_W'(1);
  assign wrap_res = (wrap_inc >= act) ? '0 : WW'(wrap_inc);

  swq_task_mem #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (STW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_addr),
    .wr_data (STW'(task_r)),
    .rd_en   (mem_re),
    .rd_addr (mem_addr),
    .rd_data (mem_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    cand_nxt   = cand_r;
    steps_nxt  = steps_r;
    rr_nxt     = rr_r;
    total_nxt  = total_r;
    res_nxt    = res_r;
    cnt_we     = 1'b0;
    cnt_wdata  = cnt_sel;
    head_we    = 1'b0;
    head_wdata = slot;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        res_nxt.task_id = '0;
        res_nxt.wake    = 1'b0;
        if (cmd_r == swq_pkg::CMD_SUBMIT) begin
          res_nxt.target = swq_pkg::WIDX_W'(q);
          state_nxt      = ST_DONE;
          if (reject) begin
            res_nxt.status = swq_pkg::STAT_FULL;
          end else begin
            res_nxt.status = swq_pkg::STAT_QUEUED;
            res_nxt.wake   = (cnt_sel == '0);
            mem_we         = 1'b1;
            cnt_we         = 1'b1;
            cnt_wdata      = cnt_sel + CW'(1);
            total_nxt      = total_r + TOT_W'(1);
            rr_nxt         = (q_inc >= act) ? '0 : WW'(q_inc);
          end
        end else begin
          res_nxt.target = req_r;
          res_nxt.status = swq_pkg::STAT_NONE;
          if (req_oor) begin
            state_nxt = ST_DONE;
          end else if (cnt_sel != '0) begin
            res_nxt.status = swq_pkg::STAT_OWN;
            mem_re         = 1'b1;
            head_we        = 1'b1;
            cnt_we         = 1'b1;
            cnt_wdata      = cnt_sel - CW'(1);
            total_nxt      = total_r - TOT_W'(1);
            state_nxt      = ST_READ;
          end else if (act == ACT_W'(1)) begin
            state_nxt = ST_DONE;
          end else begin
            cand_nxt  = wrap_res;
            steps_nxt = ACT_W'(1);
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (cnt_sel != '0) begin
          res_nxt.status = swq_pkg::STAT_STOLEN;
          res_nxt.target = swq_pkg::WIDX_W'(cand_r);
          mem_re         = 1'b1;
          cnt_we         = 1'b1;
          cnt_wdata      = cnt_sel - CW'(1);
          total_nxt      = total_r - TOT_W'(1);
          state_nxt      = ST_READ;
        end else if (steps_r == act - ACT_W'(1)) begin
          state_nxt = ST_DONE;
        end else begin
          steps_nxt = steps_r + ACT_W'(1);
          cand_nxt  = wrap_res;
        end
      end
      ST_READ: begin
        res_nxt.task_id = swq_pkg::TASK_W'(mem_rdata);
        state_nxt       = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cand_r      <= '0;
      steps_r     <= '0;
      rr_r        <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      mqs_r       <= '0;
      aw_r        <= swq_pkg::ACTIVE_RESET;
      for (int i = 0; i < MAX_WORKERS; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cand_r      <= cand_nxt;
      steps_r     <= steps_nxt;
      rr_r        <= rr_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_ch.ready);
      if (cnt_we) begin
        cnt_r[sel_w] <= cnt_wdata;
      end
      if (head_we) begin
        head_r[sel_w] <= head_wdata;
      end
      if (cfg_fire) begin
        case (cfg_ch.index)
          swq_pkg::CFG_MAX_QUEUE: mqs_r <= cfg_ch.data;
          swq_pkg::CFG_ACTIVE:    aw_r  <= swq_pkg::ACTREG_W'(cfg_ch.data);
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_ch.command;
      task_r <= in_ch.task_id;
      req_r  <= in_ch.worker_index;
    end
    res_r   <= res_nxt;
    if (out_load) begin
      out_res_r   <= res_r;
      out_total_r <= swq_pkg::TOTAL_W'(total_r);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_res_r.status;
  assign out_ch.task_id_res   = out_res_r.task_id;
  assign out_ch.target_worker = out_res_r.target;
  assign out_ch.wake          = out_res_r.wake;
  assign out_ch.queued_total  = out_total_r;

`ifndef ASSERT_OFF
  a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_EVAL)
    else $error("accepted command did not enter evaluation");

  a_read_after_grant: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> $past(state_r) == ST_EVAL || $past(state_r) == ST_SCAN)
    else $error("store read without a grant");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> steps_r < act && steps_r != '0)
    else $error("steal scan ran past the active queues");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_sel <= CW'(SHARD_DEPTH))
    else $error("queue count above shard depth");

  a_submit_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EVAL && cmd_r == swq_pkg::CMD_SUBMIT && !reject
    |=> total_r == $past(total_r) + TOT_W'(1))
    else $error("queued submit did not raise the total");

  a_wake_on_queue: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.wake |-> out_ch.status == swq_pkg::STAT_QUEUED)
    else $error("wake on a result that queued nothing");
`endif

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the sharded work-stealing task queue: directed table, then
// randomized phases over register settings, idling and back-pressure.
// Depends on swq_pkg, the swq_* channel interfaces and the unit's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Geometry of the unit as instantiated (its defaults)
  localparam int WORKERS    = 8;
  localparam int RING_DEPTH = 16;

  // Run length and pacing
  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 16;   // longer than a full steal scan
  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int BURST_LEN       = 24;
  localparam int HOLD_CYCLES     = 300;
  localparam int REPORT_LIMIT    = 10;

  // Register indexes the unit does not decode; writes there must change nothing
  localparam logic [swq_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [swq_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // One result transaction as the unit should present it
  typedef struct packed {
    logic [swq_pkg::STAT_W-1:0]  status;
    logic [swq_pkg::TASK_W-1:0]  task_id;
    logic [swq_pkg::WIDX_W-1:0]  target;
    logic                        wake;
    logic [swq_pkg::TOTAL_W-1:0] total;
  } dispatch_t;

  typedef enum int { ROW_SUB, ROW_REQ, ROW_CFG } row_kind_t;

  // Directed row: a submit (a = task id), a request (a = worker) or a register write
  // (a = index, b = value); pin carries a hand-written expectation.
  typedef struct {
    row_kind_t kind;
    int        a;
    int        b;
    bit        pin;
    dispatch_t res;
  } step_row_t;

  logic clk;
  logic rst_n;

  swq_in_if  in_bus();
  swq_out_if out_bus();
  swq_cfg_if cfg_bus();

  sharded_work_stealing_task_queue_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the dispatcher state
  // ---------------------------------------------------------------------------
  logic [swq_pkg::TASK_W-1:0]   ring_data [WORKERS][RING_DEPTH];
  int                           ring_head [WORKERS];
  int                           ring_fill [WORKERS];
  int                           rr_next;
  int                           queued_cnt;
  logic [swq_pkg::MQS_W-1:0]    limit_reg;
  logic [swq_pkg::ACTREG_W-1:0] workers_reg;

  dispatch_t pending_results[$];
  int        mismatches = 0;
  int        cycle_cnt  = 0;

  // Shared between the stimulus, the receiver and the monitor
  int        idle_pct   = 0;
  int        stall_pct  = 0;
  int        hold_until = 0;
  bit        pin_active = 1'b0;
  dispatch_t pin_expect = '0;

  // Out-of-range register values clamp into 1..WORKERS
  function automatic int active_span(logic [swq_pkg::ACTREG_W-1:0] reg_val);
    if (reg_val == 0) return 1;
    if (reg_val > WORKERS) return WORKERS;
    return int'(reg_val);
  endfunction

  // Applies one command to the shadow state and returns the result it must produce.
  function automatic dispatch_t predict_dispatch(logic cmd,
                                                 logic [swq_pkg::TASK_W-1:0] tid,
                                                 logic [swq_pkg::WIDX_W-1:0] widx);
    dispatch_t r;
    int span, q, slot, v, i, wi;
    bit found;
    r = '0;
    span = active_span(workers_reg);
    wi = int'(widx);
    if (cmd == swq_pkg::CMD_SUBMIT) begin
      // pointer left beyond the active count by a register change falls back to queue 0
      q = (rr_next < span) ? rr_next : 0;
      r.target = q[swq_pkg::WIDX_W-1:0];
      if ((limit_reg != 0 && queued_cnt >= int'(limit_reg)) ||
          ring_fill[q] >= RING_DEPTH) begin
        r.status = swq_pkg::STAT_FULL;
      end else begin
        r.status = swq_pkg::STAT_QUEUED;
        r.wake = (ring_fill[q] == 0);
        slot = (ring_head[q] + ring_fill[q]) % RING_DEPTH;
        ring_data[q][slot] = tid;
        ring_fill[q]++;
        queued_cnt++;
        rr_next = (q + 1 >= span) ? 0 : q + 1;
      end
    end else begin
      r.status = swq_pkg::STAT_NONE;
      r.target = widx;
      if (wi < span) begin
        if (ring_fill[wi] != 0) begin
          // own queue: pop the front
          slot = ring_head[wi];
          r.status = swq_pkg::STAT_OWN;
          r.task_id = ring_data[wi][slot];
          ring_head[wi] = (slot + 1) % RING_DEPTH;
          ring_fill[wi]--;
          queued_cnt--;
        end else begin
          // steal the back entry of the first non-empty queue above the requester, wrapping
          found = 1'b0;
          for (i = 1; i < span && !found; i++) begin
            v = (wi + i) % span;
            if (ring_fill[v] != 0) begin
              slot = (ring_head[v] + ring_fill[v] - 1) % RING_DEPTH;
              r.status = swq_pkg::STAT_STOLEN;
              r.task_id = ring_data[v][slot];
              r.target = v[swq_pkg::WIDX_W-1:0];
              ring_fill[v]--;
              queued_cnt--;
              found = 1'b1;
            end
          end
        end
      end
    end
    r.total = queued_cnt[swq_pkg::TOTAL_W-1:0];
    return r;
  endfunction

  function automatic step_row_t mk(row_kind_t kind, int a, int b = 0, bit pin = 1'b0,
                                   logic [swq_pkg::STAT_W-1:0] st = swq_pkg::STAT_QUEUED,
                                   int tk = 0, int tg = 0, bit wk = 1'b0, int tot = 0);
    step_row_t row;
    row.kind = kind;
    row.a = a;
    row.b = b;
    row.pin = pin;
    row.res.status = st;
    row.res.task_id = tk[swq_pkg::TASK_W-1:0];
    row.res.target = tg[swq_pkg::WIDX_W-1:0];
    row.res.wake = wk;
    row.res.total = tot[swq_pkg::TOTAL_W-1:0];
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, cycle counter and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: completed result transactions are checked against the oldest
  // expectation, then accepted commands and register writes update the shadow.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    dispatch_t got, want;
    if (!rst_n) begin
      foreach (ring_head[w]) begin
        ring_head[w] = 0;
        ring_fill[w] = 0;
      end
      rr_next = 0;
      queued_cnt = 0;
      limit_reg = '0;
      workers_reg = swq_pkg::ACTIVE_RESET;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.status  = out_bus.status;
        got.task_id = out_bus.task_id_res;
        got.target  = out_bus.target_worker;
        got.wake    = out_bus.wake;
        got.total   = out_bus.queued_total;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display({"cycle %0d: result with nothing pending:",
                      " st=%0d id=%h tgt=%0d wk=%0b tot=%0d"},
                     cycle_cnt, got.status, got.task_id, got.target, got.wake, got.total);
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (got.status !== want.status || got.task_id !== want.task_id ||
              got.target !== want.target || got.wake !== want.wake ||
              got.total !== want.total) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display({"cycle %0d: mismatch exp st=%0d id=%h tgt=%0d wk=%0b tot=%0d",
                        " | got st=%0d id=%h tgt=%0d wk=%0b tot=%0d"},
                       cycle_cnt, want.status, want.task_id, want.target, want.wake,
                       want.total, got.status, got.task_id, got.target, got.wake, got.total);
          end
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        want = predict_dispatch(in_bus.command, in_bus.task_id, in_bus.worker_index);
        if (pin_active) want = pin_expect;
        pending_results.push_back(want);
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          swq_pkg::CFG_MAX_QUEUE: limit_reg = cfg_bus.data;
          swq_pkg::CFG_ACTIVE:    workers_reg = cfg_bus.data[swq_pkg::ACTREG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls at stall_pct, plus a long hold-off window
  // ---------------------------------------------------------------------------
  initial begin : receiver
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (cycle_cnt < hold_until) out_bus.ready = 1'b0;
      else out_bus.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks; each starts and ends just after a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_cmd(input logic cmd, input logic [swq_pkg::TASK_W-1:0] tid,
                          input logic [swq_pkg::WIDX_W-1:0] widx, input bit pin,
                          input dispatch_t res);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid        = 1'b1;
    in_bus.command      = cmd;
    in_bus.task_id      = tid;
    in_bus.worker_index = widx;
    pin_active          = pin;
    pin_expect          = res;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
    in_bus.valid = 1'b0;
    pin_active   = 1'b0;
  endtask

  task automatic write_reg(input logic [swq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [swq_pkg::CFG_DATA_W-1:0] val);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = val;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // Sender pause: every expected transaction back, then a scan's worth of quiet cycles
  task automatic settle();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  int ph_limit  [PHASES] = '{  0, 128,  0,  5, 255,  1, -1, 128,  0 };  // -1: random
  int ph_active [PHASES] = '{  8,   8,  1,  3,  15,  0, -1,   8,  5 };  // -1: random 2..7
  int ph_idle   [PHASES] = '{  0,  75,  0, 18,   0, 75, 18,   0,  0 };
  int ph_stall  [PHASES] = '{  0,   0, 75, 18,   0,  0, 18,  75,  0 };

  initial begin : stimulus
    step_row_t rows[$];
    int span, submit_pct, lim, act;
    logic [3:0] hi_bits;
    logic [swq_pkg::TASK_W-1:0] tid;
    logic [swq_pkg::WIDX_W-1:0] widx;

    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.command      = swq_pkg::CMD_SUBMIT;
    in_bus.task_id      = '0;
    in_bus.worker_index = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = swq_pkg::CFG_MAX_QUEUE;
    cfg_bus.data        = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table. Fresh reset: limit off, all eight workers active.
    rows.push_back(mk(ROW_REQ, 0, 0, 1'b1, swq_pkg::STAT_NONE, 0, 0, 1'b0, 0)); // nothing queued
    rows.push_back(mk(ROW_REQ, 7, 0, 1'b1, swq_pkg::STAT_NONE, 0, 7, 1'b0, 0));
    // empty queue wakes
    rows.push_back(mk(ROW_SUB, 'hFFFF, 0, 1'b1, swq_pkg::STAT_QUEUED, 0, 0, 1'b1, 1));
    rows.push_back(mk(ROW_SUB, 'h0000, 0, 1'b1, swq_pkg::STAT_QUEUED, 0, 1, 1'b1, 2));
    rows.push_back(mk(ROW_SUB, 'hA5A5));
    // wraps past 7 to 0
    rows.push_back(mk(ROW_REQ, 5, 0, 1'b1, swq_pkg::STAT_STOLEN, 'hFFFF, 0, 1'b0, 2));
    rows.push_back(mk(ROW_REQ, 1, 0, 1'b1, swq_pkg::STAT_OWN, 'h0000, 1, 1'b0, 1));
    rows.push_back(mk(ROW_REQ, 2));
    rows.push_back(mk(ROW_CFG, swq_pkg::CFG_MAX_QUEUE, 2));
    rows.push_back(mk(ROW_SUB, 'h1234));
    rows.push_back(mk(ROW_SUB, 'h5678));
    // total limit hit
    rows.push_back(mk(ROW_SUB, 'h9ABC, 0, 1'b1, swq_pkg::STAT_FULL, 0, 5, 1'b0, 2));
    rows.push_back(mk(ROW_CFG, CFG_SPARE_A, 'hFF));                    // undecoded indexes
    rows.push_back(mk(ROW_CFG, CFG_SPARE_B, 'h00));
    rows.push_back(mk(ROW_SUB, 'h9ABC, 0, 1'b1, swq_pkg::STAT_FULL, 0, 5, 1'b0, 2));
    rows.push_back(mk(ROW_CFG, swq_pkg::CFG_ACTIVE, 3));               // queues 3, 4 parked
    rows.push_back(mk(ROW_CFG, swq_pkg::CFG_MAX_QUEUE, 0));
    // pointer 5 -> queue 0
    rows.push_back(mk(ROW_SUB, 'h0F0F, 0, 1'b1, swq_pkg::STAT_QUEUED, 0, 0, 1'b1, 3));
    // inactive requester
    rows.push_back(mk(ROW_REQ, 5, 0, 1'b1, swq_pkg::STAT_NONE, 0, 5, 1'b0, 3));
    // parked queues not stolen from
    rows.push_back(mk(ROW_REQ, 1, 0, 1'b1, swq_pkg::STAT_STOLEN, 'h0F0F, 0, 1'b0, 2));
    rows.push_back(mk(ROW_CFG, swq_pkg::CFG_ACTIVE, 0));               // acts as one worker
    rows.push_back(mk(ROW_REQ, 0, 0, 1'b1, swq_pkg::STAT_NONE, 0, 0, 1'b0, 2));
    rows.push_back(mk(ROW_SUB, 'h00FF));
    rows.push_back(mk(ROW_CFG, swq_pkg::CFG_ACTIVE, 15));              // acts as eight
    rows.push_back(mk(ROW_REQ, 3));
    rows.push_back(mk(ROW_REQ, 4));
    rows.push_back(mk(ROW_REQ, 6));
    rows.push_back(mk(ROW_REQ, 6));
    rows.push_back(mk(ROW_CFG, swq_pkg::CFG_ACTIVE, 8));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(rows[i].a[swq_pkg::CFG_IDX_W-1:0], rows[i].b[swq_pkg::CFG_DATA_W-1:0]);
      end else begin
        tid  = (rows[i].kind == ROW_SUB) ? rows[i].a[swq_pkg::TASK_W-1:0]
                                         : swq_pkg::TASK_W'($urandom_range(16'hFFFF));
        widx = (rows[i].kind == ROW_REQ) ? rows[i].a[swq_pkg::WIDX_W-1:0]
                                         : swq_pkg::WIDX_W'($urandom_range(7));
        send_cmd((rows[i].kind == ROW_REQ) ? swq_pkg::CMD_REQUEST : swq_pkg::CMD_SUBMIT,
                 tid, widx, rows[i].pin, rows[i].res);
      end
    end

    // Random phases. Each starts from an idle unit, then runs bursts whose submit share
    // swings between filling and draining so the full and empty corners both get hit.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      lim = (ph_limit[p] < 0) ? $urandom_range(255) : ph_limit[p];
      act = (ph_active[p] < 0) ? $urandom_range(7, 2) : ph_active[p];
      hi_bits = 4'($urandom_range(15));
      write_reg(swq_pkg::CFG_MAX_QUEUE, lim[swq_pkg::CFG_DATA_W-1:0]);
      write_reg(swq_pkg::CFG_ACTIVE, {hi_bits, act[swq_pkg::ACTREG_W-1:0]});
      idle_pct  = ph_idle[p];
      stall_pct = ph_stall[p];
      span = active_span(act[swq_pkg::ACTREG_W-1:0]);
      submit_pct = 50;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % BURST_LEN == 0) begin
          case ($urandom_range(2))
            0:       submit_pct = 85;
            1:       submit_pct = 50;
            default: submit_pct = 15;
          endcase
        end
        // receiver holds off while commands keep coming, so the unit backs up
        if (p == 0 && n == 40) hold_until = cycle_cnt + HOLD_CYCLES;
        tid = swq_pkg::TASK_W'($urandom_range(16'hFFFF));
        if ($urandom_range(99) < submit_pct) begin
          widx = swq_pkg::WIDX_W'($urandom_range(7));
          send_cmd(swq_pkg::CMD_SUBMIT, tid, widx, 1'b0, '0);
        end else begin
          // mostly active requesters; the rest may be parked workers
          widx = ($urandom_range(99) < 85) ? swq_pkg::WIDX_W'($urandom_range(span - 1))
                                           : swq_pkg::WIDX_W'($urandom_range(7));
          send_cmd(swq_pkg::CMD_REQUEST, tid, widx, 1'b0, '0);
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
